### design/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared widths, register indexes, result types and the CRC-16 byte update
// for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 17;
  localparam int LEN_W       = 16;
  localparam int CRC_W       = 16;
  localparam int CFG_INDEX_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // frame layout
  localparam int HEADER_BYTES = 7;
  localparam int CRC_BYTES    = 2;
  localparam logic [INDEX_W-1:0] SECOND_HEAD_POS = 17'd1;
  localparam logic [INDEX_W-1:0] LEN_LO_POS      = 17'd5;
  localparam logic [INDEX_W-1:0] LEN_HI_POS      = 17'd6;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HEAD  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HEAD = 8'd1;

  // result queue depth; must be at least 2 (a byte may yield two results)
  localparam int OUTQ_DEPTH = 4;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [LEN_W-1:0]   payload_length;
    logic               frame_last;
    logic               crc_good;
  } res_t;

  // results produced by one received byte
  typedef struct packed {
    logic [1:0] n_res;
    res_t       first;
    res_t       second;
  } push_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### design/slcfr_if.sv
// ----------------------------------------------------------------------------
// slcfr channel interfaces
// Valid/ready channels for received bytes, frame results and register writes.
// ----------------------------------------------------------------------------
interface slcfr_rx_if import slcfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcfr_res_if import slcfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic [INDEX_W-1:0] byte_index;
  logic [LEN_W-1:0]   payload_length;
  logic               frame_last;
  logic               crc_good;

  modport source (output valid, output out_byte, output byte_index,
                  output payload_length, output frame_last, output crc_good,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_index,
                  input payload_length, input frame_last, input crc_good,
                  output ready);
endinterface

interface slcfr_cfg_if import slcfr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/slcfr_outq.sv
// ----------------------------------------------------------------------------
// slcfr_outq
// Small result queue: takes up to two results per cycle, drives one result
// transaction per cycle on the output channel while res.ready is high.
// ----------------------------------------------------------------------------
module slcfr_outq import slcfr_pkg::*; #(
  parameter int DEPTH = OUTQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  push_t                push,
  output logic                 room2,
  slcfr_res_if.source          res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] wr_ptr_1;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop      = res.valid && res.ready;
  assign room2    = (count <= CNT_W'(DEPTH - 2));
  assign wr_ptr_1 = ptr_inc(wr_ptr);

  assign res.valid          = (count != '0);
  assign res.out_byte       = mem[rd_ptr].out_byte;
  assign res.byte_index     = mem[rd_ptr].byte_index;
  assign res.payload_length = mem[rd_ptr].payload_length;
  assign res.frame_last     = mem[rd_ptr].frame_last;
  assign res.crc_good       = mem[rd_ptr].crc_good;

  always_comb begin
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    unique case (push.n_res)
      2'd0:    wr_ptr_next = wr_ptr;
      2'd1:    wr_ptr_next = wr_ptr_1;
      default: wr_ptr_next = ptr_inc(wr_ptr_1);
    endcase
    count_next = count + CNT_W'(push.n_res) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n_res != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n_res == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

endmodule

### design/sync_length_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Hunts for two head bytes, follows a 7-byte header with a 16-bit length,
// and checks the trailing CRC-16 (poly 0x1021, init 0) of each frame.
//
//   channel | dir | payload                                         | transaction
//   rx      | in  | rx_byte                                         | one raw byte
//   res     | out | out_byte, byte_index, payload_length,           | one frame byte
//           |     | frame_last, crc_good                            |
//   cfg     | in  | index, data                                     | register write
//
// One byte per cycle: each byte is parsed and its CRC update done in the
// cycle it is taken; the results land in a 4-entry result queue.
// A confirmed second head byte yields two results; the queue drains one a cycle
// when res.ready is high; rx.ready drops only while fewer than two entries are free.
// rst is synchronous: frame state, head byte registers and queue clear.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_receiver import slcfr_pkg::*; #(
  parameter int OUTQ_DEPTH_P = OUTQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  slcfr_rx_if.sink     rx,
  slcfr_res_if.source  res,
  slcfr_cfg_if.sink    cfg
);

  logic [BYTE_W-1:0]  first_head, second_head;
  logic [INDEX_W-1:0] byte_count, byte_count_next;
  logic [CRC_W-1:0]   running_crc, running_crc_next;
  logic [LEN_W-1:0]   length_reg, length_reg_next;
  logic [BYTE_W-1:0]  crc_low_byte, crc_low_byte_next;

  logic               accept;
  logic               room2;
  push_t              push;
  logic [BYTE_W-1:0]  b;
  logic [LEN_W-1:0]   len_out;
  logic [INDEX_W-1:0] crc_start, last_idx;

  assign accept    = rx.valid && rx.ready;
  assign rx.ready  = room2;
  assign cfg.ready = 1'b1;
  assign b         = rx.rx_byte;

  always_comb begin
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    length_reg_next   = length_reg;
    crc_low_byte_next = crc_low_byte;
    push              = '0;
    len_out           = '0;
    crc_start         = INDEX_W'(HEADER_BYTES) + INDEX_W'(length_reg);
    last_idx          = crc_start + INDEX_W'(CRC_BYTES - 1);

    if (accept) begin
      priority if (byte_count == '0) begin
        if (b == first_head) begin
          running_crc_next = crc16_byte('0, b);
          byte_count_next  = INDEX_W'(1);
        end
      end else if (byte_count == SECOND_HEAD_POS) begin
        if (b != second_head) begin
          // a repeated first head byte starts a new frame
          if (b == first_head) begin
            running_crc_next = crc16_byte('0, b);
            byte_count_next  = INDEX_W'(1);
          end else begin
            running_crc_next = '0;
            byte_count_next  = '0;
          end
        end else begin
          running_crc_next = crc16_byte(running_crc, b);
          byte_count_next  = INDEX_W'(2);
          push.n_res       = 2'd2;
          push.first       = '{out_byte: first_head, byte_index: '0,
                               payload_length: '0, frame_last: 1'b0,
                               crc_good: 1'b0};
          push.second      = '{out_byte: b, byte_index: SECOND_HEAD_POS,
                               payload_length: '0, frame_last: 1'b0,
                               crc_good: 1'b0};
        end
      end else begin
        if (byte_count == LEN_LO_POS) begin
          length_reg_next = {8'h00, b};
        end else if (byte_count == LEN_HI_POS) begin
          length_reg_next = {b, length_reg[7:0]};
        end
        len_out   = (byte_count >= LEN_HI_POS) ? length_reg_next : '0;
        crc_start = INDEX_W'(HEADER_BYTES) + INDEX_W'(length_reg_next);
        last_idx  = crc_start + INDEX_W'(CRC_BYTES - 1);
        push.n_res = 2'd1;
        push.first = '{out_byte: b, byte_index: byte_count,
                       payload_length: len_out, frame_last: 1'b0,
                       crc_good: 1'b0};
        priority if (byte_count == last_idx) begin
          push.first.frame_last = 1'b1;
          push.first.crc_good   = ({b, crc_low_byte} == running_crc);
          byte_count_next       = '0;
          running_crc_next      = '0;
        end else if (byte_count == crc_start) begin
          // hold the low CRC byte until the high byte arrives
          crc_low_byte_next = b;
          byte_count_next   = byte_count + INDEX_W'(1);
        end else begin
          running_crc_next = crc16_byte(running_crc, b);
          byte_count_next  = byte_count + INDEX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_crc  <= '0;
      length_reg   <= '0;
      crc_low_byte <= '0;
    end else begin
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      length_reg   <= length_reg_next;
      crc_low_byte <= crc_low_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_head  <= '0;
      second_head <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FIRST_HEAD:  first_head  <= cfg.data;
        REG_SECOND_HEAD: second_head <= cfg.data;
        default: ;
      endcase
    end
  end

  slcfr_outq #(
    .DEPTH (OUTQ_DEPTH_P)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room2 (room2),
    .res   (res)
  );

endmodule

### design/slcfr_checker.sv
// ----------------------------------------------------------------------------
// slcfr_checker
// Port-level checks on the frame receiver's result channel.
// ----------------------------------------------------------------------------
module slcfr_checker import slcfr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  out_byte,
  input logic [INDEX_W-1:0] byte_index,
  input logic [LEN_W-1:0]   payload_length,
  input logic               frame_last,
  input logic               crc_good
);

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_good_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> !crc_good)
    else $error("crc_good set on a byte that is not the last");

  a_len_before_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_index < LEN_HI_POS) |-> (payload_length == '0))
    else $error("payload_length nonzero before the length is known");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(byte_index) && $stable(payload_length) &&
      $stable(frame_last) && $stable(crc_good))
    else $error("result changed while stalled");

endmodule

bind sync_length_crc16_frame_receiver slcfr_checker u_slcfr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .out_byte       (res.out_byte),
  .byte_index     (res.byte_index),
  .payload_length (res.payload_length),
  .frame_last     (res.frame_last),
  .crc_good       (res.crc_good)
);
